// ===== src/line_sensor_position_tracker_macros.svh =====
// assertion helpers shared by the tracker rtl
`ifndef LINE_SENSOR_POSITION_TRACKER_MACROS_SVH
`define LINE_SENSOR_POSITION_TRACKER_MACROS_SVH

// condition implies consequence in the same cycle
`define LSPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lspt assertion failed");

// condition implies consequence in the next cycle
`define LSPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lspt assertion failed");

`endif

// ===== src/lspt_pkg.sv =====
package lspt_pkg;

  localparam int SENSOR_BITS = 16;
  localparam int IDX_W       = $clog2(SENSOR_BITS);
  localparam int LEN_W       = $clog2(SENSOR_BITS + 1);
  localparam int CFG_W       = 5;
  localparam int POS_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int IN_DATA_W   = 24;
  localparam int SUM_W       = 9;

  localparam logic [CFG_W-1:0] MAX_POINTS_RESET = 5'd7;

  // position = POS_SCALE*start + POS_HALF*(points-1) - POS_OFFSET
  localparam logic [SUM_W-1:0] POS_SCALE  = SUM_W'(150 / (SENSOR_BITS - 1));
  localparam logic [SUM_W-1:0] POS_HALF   = SUM_W'(75 / (SENSOR_BITS - 1));
  localparam logic [SUM_W-1:0] POS_OFFSET = SUM_W'(75);

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DIR   = 1'b1;

  typedef logic [SENSOR_BITS-1:0] frame_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [LEN_W-1:0]       len_t;

  function automatic idx_t lowest_idx(input frame_t v);
    idx_t r;
    r = '0;
    for (int i = SENSOR_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = idx_t'(i);
    end
    return r;
  endfunction

  function automatic idx_t highest_idx(input frame_t v);
    idx_t r;
    r = '0;
    for (int i = 0; i < SENSOR_BITS; i++) begin
      if (v[i]) r = idx_t'(i);
    end
    return r;
  endfunction

  function automatic idx_t abs_diff(input idx_t a, input idx_t b);
    return (a >= b) ? idx_t'(a - b) : idx_t'(b - a);
  endfunction

endpackage

// ===== src/line_sensor_position_tracker.sv =====
// Line-sensor position tracker. Each frame beat (s_tuser = 0) carries 16 sensor bits; the
// block finds the runs of set bits, picks the lowest-starting run when following low or the
// highest-ending run otherwise, averages up to max_points bits at that edge and returns a
// signed position in -75..75 (m_tdata) with line_found on m_tuser; an empty frame gives
// position 0 and line_found 0. A steering beat (s_tuser = 1) sets the follow direction from
// s_tdata bit 16 and returns nothing. When one narrow run splits into several, the direction
// turns away from the run that moved farthest. Each frame beat passes the input register and
// then the result register; a new beat is taken every cycle while results are drained. The
// user must write max_points on the cfg channel only while idle; the block does not enforce it.
module line_sensor_position_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // low_byte [7:0], high_byte [15:8], prefer_high [16], zero fill [23:17]
  input  logic [lspt_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind [0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // position [7:0]
  output logic [lspt_pkg::POS_W-1:0]       m_tdata,
  // line_found [0]
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lspt_pkg::CFG_W-1:0]       cfg_data
);
  import lspt_pkg::*;

  logic [CFG_W-1:0] max_points;
  logic             follow_low;
  logic             prev_single_run;
  idx_t             prev_run_start;
  len_t             prev_run_length;

  logic             s1_valid;
  logic             s1_kind;
  frame_t           s1_frame;
  logic             s1_prefer_high;
  logic             s1_adv;
  logic             out_free;

  frame_t           starts;
  frame_t           ends;
  logic             any_run;
  logic             one_run;
  logic             many_runs;
  idx_t             first_start;
  idx_t             first_end;
  idx_t             last_start;
  idx_t             last_end;
  len_t             first_len;
  len_t             last_len;
  idx_t             best_start;
  logic             fork_hit;
  logic             dir_low;
  logic [CFG_W-1:0] mp;
  len_t             p_first;
  len_t             p_last;
  len_t             points;
  idx_t             sel_start;
  logic [SUM_W-1:0] pos_sum;

  assign cfg_ready = 1'b1;

  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && (s1_kind == KIND_DIR || out_free);
  assign s_tready = !s1_valid || s1_adv;

  // run edges
  assign starts    = s1_frame & ~(s1_frame << 1);
  assign ends      = s1_frame & ~(s1_frame >> 1);
  assign any_run   = |starts;
  assign one_run   = $onehot(starts);
  assign many_runs = any_run && !one_run;

  always_comb begin
    first_start = lowest_idx(starts);
    first_end   = lowest_idx(ends);
    last_start  = highest_idx(starts);
    last_end    = highest_idx(ends);
    first_len   = len_t'(first_end) - len_t'(first_start) + len_t'(1);
    last_len    = len_t'(last_end) - len_t'(last_start) + len_t'(1);

    // farthest start is one of the outer runs; a tie keeps the lower one
    best_start = (abs_diff(last_start, prev_run_start) > abs_diff(first_start, prev_run_start))
               ? last_start : first_start;

    mp       = (max_points == '0) ? CFG_W'(1) : max_points;
    fork_hit = prev_single_run && many_runs &&
               ({1'b0, prev_run_length} <= ({1'b0, mp} + (CFG_W+1)'(1)));
    dir_low  = fork_hit ? (best_start >= prev_run_start) : follow_low;

    p_first = ({1'b0, first_len} < {1'b0, mp}) ? first_len : len_t'(mp);
    p_last  = ({1'b0, last_len} < {1'b0, mp}) ? last_len : len_t'(mp);

    if (dir_low) begin
      points    = p_first;
      sel_start = first_start;
    end else begin
      points    = p_last;
      sel_start = idx_t'(len_t'(last_end) - p_last + len_t'(1));
    end

    pos_sum = POS_SCALE * SUM_W'(sel_start) + POS_HALF * SUM_W'(points - len_t'(1))
            - POS_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_points <= MAX_POINTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_points <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind        <= s_tuser;
      s1_frame       <= frame_t'(s_tdata[2*BYTE_W-1:0]);
      s1_prefer_high <= s_tdata[2*BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_low      <= 1'b1;
      prev_single_run <= 1'b0;
      prev_run_start  <= '0;
      prev_run_length <= '0;
    end else if (s1_adv) begin
      if (s1_kind == KIND_DIR) begin
        follow_low <= !s1_prefer_high;
      end else begin
        follow_low      <= dir_low;
        prev_single_run <= one_run;
        prev_run_start  <= one_run ? first_start : idx_t'(0);
        prev_run_length <= one_run ? first_len : len_t'(0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_kind == KIND_FRAME) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_kind == KIND_FRAME) begin
      m_tdata <= any_run ? POS_W'(pos_sum) : '0;
      m_tuser <= any_run;
    end
  end

`include "line_sensor_position_tracker_macros.svh"

  `LSPT_ASSERT_NOW(a_empty_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `LSPT_ASSERT_NOW(a_pos_range, clk, rst, m_tvalid && m_tuser, $signed(m_tdata) >= -8'sd75 && $signed(m_tdata) <= 8'sd75)
  `LSPT_ASSERT_NEXT(a_dir_write, clk, rst, s1_adv && s1_kind == KIND_DIR, follow_low == !$past(s1_prefer_high))
  `LSPT_ASSERT_NEXT(a_hold_stage, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_frame))

endmodule
